// File: src/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int KEY_W        = 32;
    localparam int CNT_OUT_W    = 8;
    localparam int STAT_W       = 2;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [STAT_W-1:0]       t_status;

    localparam logic    OP_INSERT  = 1'b0;
    localparam logic    OP_EXTRACT = 1'b1;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    typedef struct packed {
        t_key                 extracted_value;
        t_key                 top_value;
        logic [CNT_OUT_W-1:0] entry_count;
        t_status              status;
    } t_result;

endpackage

// File: src/mhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram
// Heap store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int DEPTH = mhpq_pkg::DEF_CAPACITY,
    parameter int AW    = $clog2(mhpq_pkg::DEF_CAPACITY),
    parameter int DW    = mhpq_pkg::KEY_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sift sequencer: walks the heap one level at a time through the store's
// single read port and one shared signed comparator.
// ----------------------------------------------------------------------------
module mhpq_ctrl #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
    parameter int IW       = $clog2(mhpq_pkg::DEF_CAPACITY),
    parameter int CW       = $clog2(mhpq_pkg::DEF_CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_operation,
    input  mhpq_pkg::t_key      i_key,
    input  logic                i_out_free,
    output logic                o_done,
    output mhpq_pkg::t_result   o_result,
    output logic                o_we,
    output logic [IW-1:0]       o_waddr,
    output mhpq_pkg::t_key      o_wdata,
    output logic [IW-1:0]       o_raddr,
    input  mhpq_pkg::t_key      i_rdata
);

    localparam int CHW = IW + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_UP, S_UP_CMP, S_DN_LAST, S_DN, S_DN_L, S_DN_R, S_RESP
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [IW-1:0]      r_pos, n_pos;
    mhpq_pkg::t_key     r_key, n_key;
    mhpq_pkg::t_key     r_top, n_top;
    mhpq_pkg::t_key     r_ext, n_ext;
    mhpq_pkg::t_key     r_bval, n_bval;
    logic               r_btake, n_btake;
    mhpq_pkg::t_status  r_stat, n_stat;

    mhpq_pkg::t_key     cmp_a, cmp_b;
    logic               lt;
    logic [IW-1:0]      pos_m1, parent;
    logic [CHW-1:0]     lc, rc, cnt_x;

    assign lt     = cmp_a < cmp_b;
    assign pos_m1 = r_pos - IW'(1);
    assign parent = pos_m1 >> 1;
    assign lc     = CHW'({r_pos, 1'b1});
    assign rc     = lc + CHW'(1);
    assign cnt_x  = CHW'(r_cnt);

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_key   = r_key;
        n_top   = r_top;
        n_ext   = r_ext;
        n_bval  = r_bval;
        n_btake = r_btake;
        n_stat  = r_stat;
        o_we    = 1'b0;
        o_waddr = r_pos;
        o_wdata = r_key;
        o_raddr = '0;
        cmp_a   = r_key;
        cmp_b   = i_rdata;
        o_done  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_raddr = IW'(r_cnt - CW'(1));
                if (i_valid) begin
                    n_ext  = '0;
                    n_stat = mhpq_pkg::STAT_OK;
                    if (i_operation == mhpq_pkg::OP_INSERT) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_stat  = mhpq_pkg::STAT_FULL;
                            n_state = S_RESP;
                        end else begin
                            n_pos   = IW'(r_cnt);
                            n_key   = i_key;
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_UP;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_stat  = mhpq_pkg::STAT_EMPTY;
                            n_state = S_RESP;
                        end else begin
                            n_ext   = r_top;
                            n_cnt   = r_cnt - CW'(1);
                            n_state = (r_cnt == CW'(1)) ? S_RESP : S_DN_LAST;
                        end
                    end
                end
            end
            S_UP: begin
                o_raddr = parent;
                if (r_pos == '0) begin
                    o_we    = 1'b1;
                    n_state = S_RESP;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmp_a = i_rdata;
                cmp_b = r_key;
                o_we  = 1'b1;
                if (lt) begin
                    o_wdata = i_rdata;
                    n_pos   = parent;
                    n_state = S_UP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_DN_LAST: begin
                n_key   = i_rdata;
                n_pos   = '0;
                n_state = S_DN;
            end
            S_DN: begin
                o_raddr = lc[IW-1:0];
                if (lc >= cnt_x) begin
                    o_we    = 1'b1;
                    n_state = S_RESP;
                end else begin
                    n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                o_raddr = rc[IW-1:0];
                if (rc < cnt_x) begin
                    n_bval  = lt ? i_rdata : r_key;
                    n_btake = lt;
                    n_state = S_DN_R;
                end else if (lt) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata;
                    n_pos   = lc[IW-1:0];
                    n_state = S_DN;
                end else begin
                    o_we    = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_DN_R: begin
                cmp_a = r_bval;
                o_we  = 1'b1;
                if (lt) begin
                    o_wdata = i_rdata;
                    n_pos   = rc[IW-1:0];
                    n_state = S_DN;
                end else if (r_btake) begin
                    o_wdata = r_bval;
                    n_pos   = lc[IW-1:0];
                    n_state = S_DN;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_we && (o_waddr == '0)) begin
            n_top = o_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_pos   <= n_pos;
        r_key   <= n_key;
        r_top   <= n_top;
        r_ext   <= n_ext;
        r_bval  <= n_bval;
        r_btake <= n_btake;
        r_stat  <= n_stat;
    end

    assign o_result.extracted_value = r_ext;
    assign o_result.top_value       = (r_cnt != '0) ? r_top : '0;
    assign o_result.entry_count     = mhpq_pkg::CNT_OUT_W'(r_cnt);
    assign o_result.status          = r_stat;

endmodule

// File: src/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// Insert: runs the sift-up loop of read parent, compare, write per level.
// Extract: runs the sift-down loop of two child reads on the single store read port.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: clears the entry count and the handshake state; store contents are kept.
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue of signed keys with insert and extract.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_operation,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_key,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_extracted_value,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_top_value,
    output logic [mhpq_pkg::CNT_OUT_W-1:0]    o_entry_count,
    output logic [mhpq_pkg::STAT_W-1:0]       o_status
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic               we;
    logic [IW-1:0]      waddr, raddr;
    mhpq_pkg::t_key     wdata, rdata;
    logic               out_free, done;
    mhpq_pkg::t_result  result;
    mhpq_pkg::t_result  r_res;
    logic               r_valid;

    assign out_free = !r_valid || i_ready;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (mhpq_pkg::KEY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mhpq_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_out_free  (out_free),
        .o_done      (done),
        .o_result    (result),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (done) begin
            r_res <= result;
        end
    end

    assign o_valid           = r_valid;
    assign o_extracted_value = r_res.extracted_value;
    assign o_top_value       = r_res.top_value;
    assign o_entry_count     = r_res.entry_count;
    assign o_status          = r_res.status;

endmodule

// File: tb/tb_max_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking bench for the max-heap priority queue. A short table of
// requests covers reset, key extremes, empty and tie cases. Phases of random
// fill, drain and mixed traffic follow, pushing the heap to full and empty.
// Results are compared with a behavioral heap model, or with the table for typed rows.
// Both sides idle at random. Once, the result side holds off for a long time.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;

    localparam int             CAPACITY        = mhpq_pkg::DEF_CAPACITY;
    localparam int             RANDOM_REQUESTS = 750;
    localparam int             HOLD_OFF_AT     = 250;
    localparam int             HOLD_OFF_CYCLES = 300;
    localparam int             DRAIN_CYCLES    = 40;
    localparam int             QUIET_LEN       = 20;
    localparam mhpq_pkg::t_key KEY_MAX         = 32'sh7FFF_FFFF;
    localparam mhpq_pkg::t_key KEY_MIN         = 32'sh8000_0000;
    localparam mhpq_pkg::t_key KEY_NEG1        = -32'sd1;

    typedef struct packed {
        logic              op;
        mhpq_pkg::t_key    key;
        logic              typed;
        mhpq_pkg::t_result want;
    } t_stim_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           i_operation = mhpq_pkg::OP_INSERT;
    mhpq_pkg::t_key                 i_key       = '0;
    logic                           i_ready     = 1'b0;
    logic                           o_ready;
    logic                           o_valid;
    mhpq_pkg::t_key                 o_extracted_value;
    mhpq_pkg::t_key                 o_top_value;
    logic [mhpq_pkg::CNT_OUT_W-1:0] o_entry_count;
    logic [mhpq_pkg::STAT_W-1:0]    o_status;

    mhpq_pkg::t_key    heap_keys [CAPACITY];
    int                heap_count   = 0;
    mhpq_pkg::t_result pending_results [$];
    t_stim_row         directed_rows [$];
    int                error_count  = 0;
    int                results_seen = 0;
    int                send_quiet   = 0;
    int                recv_quiet   = 0;

    max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_key            (i_key),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_extracted_value(o_extracted_value),
        .o_top_value      (o_top_value),
        .o_entry_count    (o_entry_count),
        .o_status         (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic mhpq_pkg::t_result predict_heap(input logic op,
                                                       input mhpq_pkg::t_key key);
        mhpq_pkg::t_result r;
        mhpq_pkg::t_key    tmp;
        int                pos;
        int                parent;
        int                best;
        int                lc;
        int                rc;
        bit                done;
        r        = '0;
        r.status = mhpq_pkg::STAT_OK;
        done     = 1'b0;
        if (op == mhpq_pkg::OP_INSERT) begin
            if (heap_count >= CAPACITY) begin
                r.status = mhpq_pkg::STAT_FULL;
            end else begin
                heap_keys[heap_count] = key;
                pos = heap_count;
                heap_count++;
                while (pos != 0 && !done) begin
                    parent = (pos - 1) / 2;
                    if (!(heap_keys[parent] < heap_keys[pos])) begin
                        done = 1'b1;
                    end else begin
                        tmp               = heap_keys[parent];
                        heap_keys[parent] = heap_keys[pos];
                        heap_keys[pos]    = tmp;
                        pos               = parent;
                    end
                end
            end
        end else begin
            if (heap_count == 0) begin
                r.status = mhpq_pkg::STAT_EMPTY;
            end else begin
                r.extracted_value = heap_keys[0];
                heap_count--;
                if (heap_count > 0) begin
                    heap_keys[0] = heap_keys[heap_count];
                    pos = 0;
                    while (!done) begin
                        best = pos;
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        if (lc < heap_count && heap_keys[best] < heap_keys[lc]) best = lc;
                        if (rc < heap_count && heap_keys[best] < heap_keys[rc]) best = rc;
                        if (best == pos) begin
                            done = 1'b1;
                        end else begin
                            tmp             = heap_keys[pos];
                            heap_keys[pos]  = heap_keys[best];
                            heap_keys[best] = tmp;
                            pos             = best;
                        end
                    end
                end
            end
        end
        r.top_value   = (heap_count > 0) ? heap_keys[0] : '0;
        r.entry_count = mhpq_pkg::CNT_OUT_W'(heap_count);
        return r;
    endfunction

    function automatic mhpq_pkg::t_key random_key();
        mhpq_pkg::t_key k;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       k = KEY_MAX;
                    1:       k = KEY_MIN;
                    2:       k = '0;
                    3:       k = KEY_NEG1;
                    default: k = 32'sd1;
                endcase
            end
            1, 2: begin
                k = $urandom_range(0, 15);
                k = k - 32'sd8;
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic add_row(input logic op, input mhpq_pkg::t_key key, input logic typed,
                           input mhpq_pkg::t_key ext, input mhpq_pkg::t_key top,
                           input int cnt, input mhpq_pkg::t_status st);
        t_stim_row row;
        row.op                   = op;
        row.key                  = key;
        row.typed                = typed;
        row.want.extracted_value = ext;
        row.want.top_value       = top;
        row.want.entry_count     = mhpq_pkg::CNT_OUT_W'(cnt);
        row.want.status          = st;
        directed_rows.push_back(row);
    endtask

    task automatic issue_request(input logic op, input mhpq_pkg::t_key key,
                                 input logic typed, input mhpq_pkg::t_result typed_want);
        mhpq_pkg::t_result want;
        int                gap;
        if (send_quiet > 0) begin
            send_quiet--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 31) == 0) send_quiet = QUIET_LEN;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        do @(posedge i_clk); while (!o_ready);
        want = predict_heap(op, key);
        if (typed) want = typed_want;
        pending_results.push_back(want);
    endtask

    task automatic check_result(input mhpq_pkg::t_result got);
        mhpq_pkg::t_result want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: extracted_value %0d, status %0d",
                   got.extracted_value, got.status);
            error_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.extracted_value !== want.extracted_value) begin
                $error("extracted_value mismatch: expected %0d, actual %0d",
                       want.extracted_value, got.extracted_value);
                error_count++;
            end
            if (got.top_value !== want.top_value) begin
                $error("top_value mismatch: expected %0d, actual %0d",
                       want.top_value, got.top_value);
                error_count++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count mismatch: expected %0d, actual %0d",
                       want.entry_count, got.entry_count);
                error_count++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d",
                       want.status, got.status);
                error_count++;
            end
        end
    endtask

    initial begin
        int                stall;
        mhpq_pkg::t_result got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (results_seen == HOLD_OFF_AT) begin
                stall = HOLD_OFF_CYCLES;
            end else if (recv_quiet > 0) begin
                recv_quiet--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
                if ($urandom_range(0, 31) == 0) recv_quiet = QUIET_LEN;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results_seen++;
            got.extracted_value = o_extracted_value;
            got.top_value       = o_top_value;
            got.entry_count     = o_entry_count;
            got.status          = o_status;
            check_result(got);
        end
    end

    initial begin
        int        sent;
        int        phase;
        int        phase_len;
        int        ins_pct;
        logic      op;
        t_stim_row row;

        // reset, extremes, empty extract
        add_row(mhpq_pkg::OP_EXTRACT, KEY_NEG1, 1'b1, '0, '0, 0, mhpq_pkg::STAT_EMPTY);
        add_row(mhpq_pkg::OP_INSERT,  KEY_MAX,  1'b1, '0, KEY_MAX, 1, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_INSERT,  KEY_MIN,  1'b1, '0, KEY_MAX, 2, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, '0, 1'b1, KEY_MAX, KEY_MIN, 1, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, KEY_MAX, 1'b1, KEY_MIN, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, '0,       1'b1, '0, '0, 0, mhpq_pkg::STAT_EMPTY);
        add_row(mhpq_pkg::OP_INSERT,  '0,       1'b1, '0, '0, 1, mhpq_pkg::STAT_OK);
        // equal keys and mixed signs
        add_row(mhpq_pkg::OP_INSERT,  KEY_NEG1, 1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_INSERT,  32'sd5,   1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_INSERT,  32'sd5,   1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_INSERT,  32'sd3,   1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_INSERT,  KEY_MIN,  1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_INSERT,  KEY_MAX,  1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_INSERT,  32'sd7,   1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, KEY_NEG1, 1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, '0,       1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, KEY_MIN,  1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, KEY_MAX,  1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, 32'sd5,   1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, KEY_NEG1, 1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, '0,       1'b0, '0, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, KEY_NEG1, 1'b1, KEY_MIN, '0, 0, mhpq_pkg::STAT_OK);
        add_row(mhpq_pkg::OP_EXTRACT, KEY_MAX,  1'b1, '0, '0, 0, mhpq_pkg::STAT_EMPTY);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[idx]) begin
            row = directed_rows[idx];
            issue_request(row.op, row.key, row.typed, row.want);
        end

        // fill, drain and mixed phases
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_REQUESTS) begin
            case (phase % 3)
                0: begin
                    phase_len = 200;
                    ins_pct   = 95;
                end
                1: begin
                    phase_len = 200;
                    ins_pct   = 5;
                end
                default: begin
                    phase_len = $urandom_range(60, 160);
                    ins_pct   = 50;
                end
            endcase
            for (int n = 0; n < phase_len && sent < RANDOM_REQUESTS; n++) begin
                op = ($urandom_range(0, 99) < ins_pct) ? mhpq_pkg::OP_INSERT
                                                       : mhpq_pkg::OP_EXTRACT;
                issue_request(op, random_key(), 1'b0, '0);
                sent++;
            end
            phase++;
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
